@@ design/rrt_pkg.sv @@
// shared types, codes and sizes of the region reference tracker
package rrt_pkg;

  localparam int FREE_SLOTS_DEF = 16;
  localparam int USED_SLOTS_DEF = 16;
  // slot index width in result structs, enough for the largest table
  localparam int SLOT_W = 10;
  localparam int ADDR_W = 48;
  localparam int END_W = 49;
  localparam int CNT_W = 16;
  localparam int TOT_W = 32;
  localparam int PS_W = 5;
  localparam int PS_RESET = 12;
  localparam int RND_W = 50;

  // byte address of the page shift register
  localparam logic [1:0] ADDR_PAGE_SHIFT = 2'd0;

  typedef enum logic [2:0] {
    FN_ADD     = 3'd0,
    FN_REF     = 3'd1,
    FN_RELEASE = 3'd2,
    FN_CHK_FREE = 3'd3,
    FN_CHK_REF = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OVERLAP = 2'd1,
    ST_INVALID = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PA_NONE     = 2'd0,
    PA_NOACCESS = 2'd1,
    PA_RW       = 2'd2
  } prot_e;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [END_W-1:0]  fend;
  } free_ent_t;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] len;
    logic [CNT_W-1:0]  rd;
    logic [CNT_W-1:0]  wr;
  } used_ent_t;

  // bounding free intervals and first empty free slot
  typedef struct packed {
    logic              p_ok;
    logic [SLOT_W-1:0] p_idx;
    logic [ADDR_W-1:0] p_start;
    logic [END_W-1:0]  p_end;
    logic              q_ok;
    logic [SLOT_W-1:0] q_idx;
    logic [ADDR_W-1:0] q_start;
    logic [END_W-1:0]  q_end;
    logic              e_ok;
    logic [SLOT_W-1:0] e_idx;
  } free_res_t;

  // bounding referenced intervals and first empty used slot
  typedef struct packed {
    logic              up_ok;
    logic [ADDR_W-1:0] up_start;
    logic [END_W-1:0]  up_end;
    logic              ue_ok;
    logic [SLOT_W-1:0] ue_idx;
    logic [ADDR_W-1:0] ue_start;
    logic [ADDR_W-1:0] ue_len;
    logic [END_W-1:0]  ue_end;
    logic [CNT_W-1:0]  ue_rd;
    logic [CNT_W-1:0]  ue_wr;
    logic              un_ok;
    logic [ADDR_W-1:0] un_start;
    logic              e_ok;
    logic [SLOT_W-1:0] e_idx;
  } used_res_t;

endpackage

@@ design/rrt_if.sv @@
// request and response channel interfaces of the tracker
interface rrt_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [47:0] start_addr;
  logic [47:0] length;
  logic        writable;

  modport source (output valid, func, start_addr, length, writable, input ready);
  modport sink (input valid, func, start_addr, length, writable, output ready);
endinterface

interface rrt_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        answer;
  logic [1:0]  prot_action;
  logic [47:0] prot_page;
  logic [48:0] prot_pages;
  logic [31:0] ref_total;
  logic [31:0] object_total;

  modport source (output valid, status, answer, prot_action, prot_page, prot_pages,
                  ref_total, object_total, input ready);
  modport sink (input valid, status, answer, prot_action, prot_page, prot_pages,
                ref_total, object_total, output ready);
endinterface

@@ design/rrt_ram.sv @@
// generic simple dual port ram with registered read
module rrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ design/rrt_cfg.sv @@
// apb configuration register block holding the page shift
module rrt_cfg import rrt_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [1:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready,
  output logic [PS_W-1:0] page_shift_o
);

  logic [PS_W-1:0] page_shift_q;

  // register write on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_shift_q <= PS_W'(PS_RESET);
    end else if (psel && penable && pwrite) begin
      page_shift_q <= pwdata[PS_W-1:0];
    end
  end

  // read back
  assign prdata = (paddr == ADDR_PAGE_SHIFT) ? {{(32-PS_W){1'b0}}, page_shift_q} : 32'd0;
  assign pready = 1'b1;
  assign page_shift_o = page_shift_q;

endmodule

@@ design/rrt_scan.sv @@
// search unit: walks both tables one entry a cycle and keeps the bounding entries
module rrt_scan import rrt_pkg::*; #(
  parameter int FREE_SLOTS = FREE_SLOTS_DEF,
  parameter int USED_SLOTS = USED_SLOTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          clr_i,
  input  logic [ADDR_W-1:0]             key_i,
  input  logic                          f_vld_i,
  input  logic [$clog2(FREE_SLOTS)-1:0] f_idx_i,
  input  logic                          f_valid_i,
  input  free_ent_t                     f_data_i,
  input  logic                          u_vld_i,
  input  logic [$clog2(USED_SLOTS)-1:0] u_idx_i,
  input  logic                          u_valid_i,
  input  used_ent_t                     u_data_i,
  output free_res_t                     f_res_o,
  output used_res_t                     u_res_o
);

  free_res_t fr_q;
  used_res_t ur_q;
  logic [END_W-1:0] u_end;

  assign u_end = {1'b0, u_data_i.start} + {1'b0, u_data_i.len};

  // free table: largest start below key, smallest start at or above key, first empty slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_q <= '0;
    end else if (clr_i) begin
      fr_q <= '0;
    end else if (f_vld_i) begin
      if (f_valid_i) begin
        if (f_data_i.start < key_i && (!fr_q.p_ok || f_data_i.start > fr_q.p_start)) begin
          fr_q.p_ok    <= 1'b1;
          fr_q.p_idx   <= SLOT_W'(f_idx_i);
          fr_q.p_start <= f_data_i.start;
          fr_q.p_end   <= f_data_i.fend;
        end
        if (f_data_i.start >= key_i && (!fr_q.q_ok || f_data_i.start < fr_q.q_start)) begin
          fr_q.q_ok    <= 1'b1;
          fr_q.q_idx   <= SLOT_W'(f_idx_i);
          fr_q.q_start <= f_data_i.start;
          fr_q.q_end   <= f_data_i.fend;
        end
      end else if (!fr_q.e_ok) begin
        fr_q.e_ok  <= 1'b1;
        fr_q.e_idx <= SLOT_W'(f_idx_i);
      end
    end
  end

  // used table: below, at or above, and strictly above the key, and first empty slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ur_q <= '0;
    end else if (clr_i) begin
      ur_q <= '0;
    end else if (u_vld_i) begin
      if (u_valid_i) begin
        if (u_data_i.start < key_i && (!ur_q.up_ok || u_data_i.start > ur_q.up_start)) begin
          ur_q.up_ok    <= 1'b1;
          ur_q.up_start <= u_data_i.start;
          ur_q.up_end   <= u_end;
        end
        if (u_data_i.start >= key_i && (!ur_q.ue_ok || u_data_i.start < ur_q.ue_start)) begin
          ur_q.ue_ok    <= 1'b1;
          ur_q.ue_idx   <= SLOT_W'(u_idx_i);
          ur_q.ue_start <= u_data_i.start;
          ur_q.ue_len   <= u_data_i.len;
          ur_q.ue_end   <= u_end;
          ur_q.ue_rd    <= u_data_i.rd;
          ur_q.ue_wr    <= u_data_i.wr;
        end
        if (u_data_i.start > key_i && (!ur_q.un_ok || u_data_i.start < ur_q.un_start)) begin
          ur_q.un_ok    <= 1'b1;
          ur_q.un_start <= u_data_i.start;
        end
      end else if (!ur_q.e_ok) begin
        ur_q.e_ok  <= 1'b1;
        ur_q.e_idx <= SLOT_W'(u_idx_i);
      end
    end
  end

  assign f_res_o = fr_q;
  assign u_res_o = ur_q;

endmodule

@@ design/region_reference_tracker.sv @@
// Region reference tracker top level. One transaction is taken at a time:
// after acceptance the search unit walks the free and used tables, each
// held in a ram with one read port, one entry per cycle, then S_EXEC
// decides, S_WR0 and S_WR1 write back to the free ram (S_WR0 also to the
// used ram), and S_PROT rounds the page range before the result is offered.
// The next request is taken while the previous result waits in the output
// register. Valid bits reset in flip-flops, so no clearing pass.
module region_reference_tracker import rrt_pkg::*; #(
  parameter int FREE_SLOTS = FREE_SLOTS_DEF,
  parameter int USED_SLOTS = USED_SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rrt_req_if.sink     req_i,
  rrt_rsp_if.source   rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int FAW = $clog2(FREE_SLOTS);
  localparam int UAW = $clog2(USED_SLOTS);
  localparam int NSCAN = (FREE_SLOTS > USED_SLOTS) ? FREE_SLOTS : USED_SLOTS;
  localparam int NW = $clog2(NSCAN + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_EXEC, S_WR0, S_WR1, S_PROT, S_DONE
  } state_e;

  state_e state_q;
  logic [NW-1:0] cnt_q;

  logic [PS_W-1:0] page_shift;

  // latched request
  func_e             func_q;
  logic [ADDR_W-1:0] s_q;
  logic [ADDR_W-1:0] len_q;
  logic [END_W-1:0]  e_q;
  logic              wr_q;

  logic [FREE_SLOTS-1:0] free_vld_q, free_vld_d;
  logic [USED_SLOTS-1:0] used_vld_q, used_vld_d;

  // read pipeline
  logic           f_re, u_re;
  logic           f_pipe_q, u_pipe_q;
  logic [FAW-1:0] f_idx_q;
  logic [UAW-1:0] u_idx_q;
  free_ent_t      f_rdata;
  used_ent_t      u_rdata;
  free_res_t      fr;
  used_res_t      ur;

  // write back commands
  logic           fw0_en_q, fw1_en_q, uw_en_q;
  logic [FAW-1:0] fw0_idx_q, fw1_idx_q;
  free_ent_t      fw0_data_q, fw1_data_q;
  logic [UAW-1:0] uw_idx_q;
  used_ent_t      uw_data_q;
  logic           f_we;
  logic [FAW-1:0] f_waddr;
  free_ent_t      f_wdata;

  // results
  status_e           status_q;
  logic              answer_q;
  prot_e             act_q;
  logic [RND_W-1:0]  pa_q, pb_q;
  logic [TOT_W-1:0]  live_refs_q, live_objs_q;

  // output register
  logic              out_vld_q;
  status_e           o_status_q;
  logic              o_answer_q;
  prot_e             o_act_q;
  logic [ADDR_W-1:0] o_page_q;
  logic [END_W-1:0]  o_pages_q;
  logic [TOT_W-1:0]  o_refs_q, o_objs_q;
  logic              out_load;

  // decision signals
  status_e        st_d;
  logic           ans_d;
  logic           fw0_en_d, fw1_en_d, uw_en_d;
  logic [FAW-1:0] fw0_idx_d, fw1_idx_d;
  free_ent_t      fw0_data_d, fw1_data_d;
  logic [UAW-1:0] uw_idx_d;
  used_ent_t      uw_data_d;
  logic           fset_en, fclr_en, uset_en, uclr_en;
  logic [FAW-1:0] fset_idx, fclr_idx;
  logic [UAW-1:0] uset_idx, uclr_idx;
  logic           refs_inc, refs_dec, objs_inc, objs_dec;
  prot_e          act_d;
  logic [RND_W-1:0] pa_d, pb_d;

  logic              len0, p_bad, q_bad, mp, mq, ue_hit, used_ovl, in_prev, in_eq, do_ins;
  status_e           fc_st;
  logic [ADDR_W-1:0] ins_ns;
  logic [END_W-1:0]  ins_ne;
  logic [FAW-1:0]    ins_slot;
  logic [CNT_W-1:0]  cnt_sel, cnt_oth;

  logic [RND_W-1:0] pmask, lo_d, hi_d, span;

  rrt_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .page_shift_o(page_shift)
  );

  // table rams
  assign f_re = (state_q == S_SCAN) && (cnt_q < NW'(FREE_SLOTS));
  assign u_re = (state_q == S_SCAN) && (cnt_q < NW'(USED_SLOTS));
  assign f_we = ((state_q == S_WR0) && fw0_en_q) || ((state_q == S_WR1) && fw1_en_q);
  assign f_waddr = (state_q == S_WR1) ? fw1_idx_q : fw0_idx_q;
  assign f_wdata = (state_q == S_WR1) ? fw1_data_q : fw0_data_q;

  rrt_ram #(.WIDTH($bits(free_ent_t)), .DEPTH(FREE_SLOTS)) u_free_ram (
    .clk_i, .we_i(f_we), .waddr_i(f_waddr), .wdata_i(f_wdata),
    .re_i(f_re), .raddr_i(cnt_q[FAW-1:0]), .rdata_o(f_rdata)
  );

  rrt_ram #(.WIDTH($bits(used_ent_t)), .DEPTH(USED_SLOTS)) u_used_ram (
    .clk_i, .we_i((state_q == S_WR0) && uw_en_q), .waddr_i(uw_idx_q), .wdata_i(uw_data_q),
    .re_i(u_re), .raddr_i(cnt_q[UAW-1:0]), .rdata_o(u_rdata)
  );

  rrt_scan #(.FREE_SLOTS(FREE_SLOTS), .USED_SLOTS(USED_SLOTS)) u_scan (
    .clk_i, .rst_ni,
    .clr_i(req_i.valid && req_i.ready),
    .key_i(s_q),
    .f_vld_i(f_pipe_q), .f_idx_i(f_idx_q), .f_valid_i(free_vld_q[f_idx_q]),
    .f_data_i(f_rdata),
    .u_vld_i(u_pipe_q), .u_idx_i(u_idx_q), .u_valid_i(used_vld_q[u_idx_q]),
    .u_data_i(u_rdata),
    .f_res_o(fr), .u_res_o(ur)
  );

  assign req_i.ready = (state_q == S_IDLE);

  // shared free and used table checks
  assign len0 = (len_q == '0);
  assign p_bad = fr.p_ok && (fr.p_end > {1'b0, s_q});
  assign q_bad = fr.q_ok && ({1'b0, fr.q_start} < e_q);
  assign mp = fr.p_ok && (fr.p_end == {1'b0, s_q});
  assign mq = fr.q_ok && ({1'b0, fr.q_start} == e_q);
  assign fc_st = (p_bad || q_bad) ? ST_INVALID :
                 (!mp && !mq && !fr.e_ok) ? ST_FULL : ST_OK;
  assign ins_ns = mp ? fr.p_start : s_q;
  assign ins_ne = mq ? fr.q_end : e_q;
  assign ins_slot = mp ? fr.p_idx[FAW-1:0] : (mq ? fr.q_idx[FAW-1:0] : fr.e_idx[FAW-1:0]);
  assign ue_hit = ur.ue_ok && (ur.ue_start == s_q);
  assign used_ovl = (ur.up_ok && (ur.up_end > {1'b0, s_q})) ||
                    (ur.un_ok && ({1'b0, ur.un_start} < e_q));
  assign in_prev = fr.p_ok && (fr.p_end >= e_q);
  assign in_eq = !in_prev && fr.q_ok && (fr.q_start == s_q) && (fr.q_end >= e_q);
  assign cnt_sel = wr_q ? ur.ue_wr : ur.ue_rd;
  assign cnt_oth = wr_q ? ur.ue_rd : ur.ue_wr;

  // operation decision
  always_comb begin
    st_d = ST_OK;
    ans_d = 1'b0;
    fw0_en_d = 1'b0;
    fw1_en_d = 1'b0;
    uw_en_d = 1'b0;
    fw0_idx_d = fr.e_idx[FAW-1:0];
    fw1_idx_d = fr.p_idx[FAW-1:0];
    fw0_data_d = '{start: e_q[ADDR_W-1:0], fend: fr.p_end};
    fw1_data_d = '{start: fr.p_start, fend: {1'b0, s_q}};
    uw_idx_d = ur.ue_idx[UAW-1:0];
    uw_data_d = '{start: ur.ue_start, len: ur.ue_len, rd: ur.ue_rd, wr: ur.ue_wr};
    fset_en = 1'b0;
    fset_idx = fr.e_idx[FAW-1:0];
    fclr_en = 1'b0;
    fclr_idx = fr.q_idx[FAW-1:0];
    uset_en = 1'b0;
    uset_idx = ur.e_idx[UAW-1:0];
    uclr_en = 1'b0;
    uclr_idx = ur.ue_idx[UAW-1:0];
    refs_inc = 1'b0;
    refs_dec = 1'b0;
    objs_inc = 1'b0;
    objs_dec = 1'b0;
    act_d = PA_NONE;
    pa_d = '0;
    pb_d = '0;
    do_ins = 1'b0;
    unique case (func_q)
      FN_ADD: begin
        if (len0) begin
          st_d = ST_INVALID;
        end else if (used_ovl || (ur.ue_ok && ({1'b0, ur.ue_start} < e_q))) begin
          st_d = ST_OVERLAP;
        end else begin
          st_d = fc_st;
          do_ins = (fc_st == ST_OK);
        end
      end
      FN_REF: begin
        if (len0) begin
          st_d = ST_INVALID;
        end else if (ue_hit) begin
          if (ur.ue_len != len_q) begin
            st_d = ST_INVALID;
          end else begin
            uw_en_d = 1'b1;
            if (cnt_sel != '1) begin
              if (wr_q) begin
                uw_data_d.wr = ur.ue_wr + 1'b1;
              end else begin
                uw_data_d.rd = ur.ue_rd + 1'b1;
              end
            end
            refs_inc = 1'b1;
          end
        end else if (used_ovl || (!in_prev && !in_eq)) begin
          st_d = ST_INVALID;
        end else if (!ur.e_ok || (in_prev && (fr.p_end > e_q) && !fr.e_ok)) begin
          st_d = ST_FULL;
        end else begin
          if (in_prev) begin
            if (fr.p_end > e_q) begin
              fw0_en_d = 1'b1;
              fset_en = 1'b1;
            end
            fw1_en_d = 1'b1;
          end else if (fr.q_end > e_q) begin
            fw0_en_d = 1'b1;
            fw0_idx_d = fr.q_idx[FAW-1:0];
            fw0_data_d = '{start: e_q[ADDR_W-1:0], fend: fr.q_end};
          end else begin
            fclr_en = 1'b1;
          end
          act_d = PA_RW;
          pa_d = {2'b00, s_q};
          pb_d = {1'b0, e_q};
          uw_en_d = 1'b1;
          uw_idx_d = ur.e_idx[UAW-1:0];
          uw_data_d = '{start: s_q, len: len_q,
                        rd: wr_q ? CNT_W'(0) : CNT_W'(1),
                        wr: wr_q ? CNT_W'(1) : CNT_W'(0)};
          uset_en = 1'b1;
          refs_inc = 1'b1;
          objs_inc = 1'b1;
        end
      end
      FN_RELEASE: begin
        if (len0 || !ue_hit || (ur.ue_len != len_q) || (cnt_sel == '0)) begin
          st_d = ST_INVALID;
        end else if ((cnt_sel == CNT_W'(1)) && (cnt_oth == '0) && (fc_st != ST_OK)) begin
          st_d = fc_st;
        end else begin
          uw_en_d = 1'b1;
          if (wr_q) begin
            uw_data_d.wr = ur.ue_wr - 1'b1;
          end else begin
            uw_data_d.rd = ur.ue_rd - 1'b1;
          end
          refs_dec = 1'b1;
          if ((cnt_sel == CNT_W'(1)) && (cnt_oth == '0)) begin
            uclr_en = 1'b1;
            do_ins = 1'b1;
            objs_dec = 1'b1;
          end
        end
      end
      FN_CHK_FREE: begin
        ans_d = (fr.q_ok && (fr.q_start == s_q) && (e_q <= fr.q_end)) ||
                (fr.p_ok && (e_q <= fr.p_end));
      end
      FN_CHK_REF: begin
        ans_d = ue_hit && (ur.ue_end == e_q);
      end
      default: begin
        st_d = ST_INVALID;
      end
    endcase
    // merge an interval into the free table
    if (do_ins) begin
      fw0_en_d = 1'b1;
      fw0_idx_d = ins_slot;
      fw0_data_d = '{start: ins_ns, fend: ins_ne};
      fset_en = 1'b1;
      fset_idx = ins_slot;
      fclr_en = mp && mq;
      act_d = PA_NOACCESS;
      pa_d = {2'b00, ins_ns};
      pb_d = {1'b0, ins_ne};
    end
  end

  // next valid bits
  always_comb begin
    free_vld_d = free_vld_q;
    used_vld_d = used_vld_q;
    if (fclr_en) begin
      free_vld_d[fclr_idx] = 1'b0;
    end
    if (fset_en) begin
      free_vld_d[fset_idx] = 1'b1;
    end
    if (uclr_en) begin
      used_vld_d[uclr_idx] = 1'b0;
    end
    if (uset_en) begin
      used_vld_d[uset_idx] = 1'b1;
    end
  end

  // page rounding
  assign pmask = (RND_W'(1) << page_shift) - RND_W'(1);
  assign lo_d = (act_q == PA_NOACCESS) ? ((pa_q + pmask) & ~pmask) : (pa_q & ~pmask);
  assign hi_d = (act_q == PA_NOACCESS) ? (pb_q & ~pmask) : ((pb_q + pmask) & ~pmask);
  assign span = pb_q - pa_q;
  assign out_load = (state_q == S_DONE) && (!out_vld_q || rsp_o.ready);

  // sequencer, valid bits and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      f_pipe_q <= 1'b0;
      u_pipe_q <= 1'b0;
      free_vld_q <= '0;
      used_vld_q <= '0;
      live_refs_q <= '0;
      live_objs_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      f_pipe_q <= f_re;
      u_pipe_q <= u_re;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            cnt_q <= '0;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (cnt_q != NW'(NSCAN)) begin
            cnt_q <= cnt_q + 1'b1;
          end else if (!f_pipe_q && !u_pipe_q) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          free_vld_q <= free_vld_d;
          used_vld_q <= used_vld_d;
          if (refs_inc && (live_refs_q != '1)) begin
            live_refs_q <= live_refs_q + 1'b1;
          end
          if (refs_dec && (live_refs_q != '0)) begin
            live_refs_q <= live_refs_q - 1'b1;
          end
          if (objs_inc && (live_objs_q != '1)) begin
            live_objs_q <= live_objs_q + 1'b1;
          end
          if (objs_dec && (live_objs_q != '0)) begin
            live_objs_q <= live_objs_q - 1'b1;
          end
          state_q <= S_WR0;
        end
        S_WR0: begin
          state_q <= S_WR1;
        end
        S_WR1: begin
          state_q <= S_PROT;
        end
        S_PROT: begin
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    f_idx_q <= cnt_q[FAW-1:0];
    u_idx_q <= cnt_q[UAW-1:0];
    if (req_i.valid && req_i.ready) begin
      func_q <= func_e'(req_i.func);
      s_q <= req_i.start_addr;
      len_q <= req_i.length;
      e_q <= {1'b0, req_i.start_addr} + {1'b0, req_i.length};
      wr_q <= req_i.writable;
    end
    if (state_q == S_EXEC) begin
      status_q <= st_d;
      answer_q <= ans_d;
      act_q <= act_d;
      pa_q <= pa_d;
      pb_q <= pb_d;
      fw0_en_q <= fw0_en_d;
      fw0_idx_q <= fw0_idx_d;
      fw0_data_q <= fw0_data_d;
      fw1_en_q <= fw1_en_d;
      fw1_idx_q <= fw1_idx_d;
      fw1_data_q <= fw1_data_d;
      uw_en_q <= uw_en_d;
      uw_idx_q <= uw_idx_d;
      uw_data_q <= uw_data_d;
    end
    if (state_q == S_PROT) begin
      pa_q <= lo_d;
      pb_q <= hi_d;
    end
    if (out_load) begin
      o_status_q <= status_q;
      o_answer_q <= answer_q;
      o_refs_q <= live_refs_q;
      o_objs_q <= live_objs_q;
      if (pb_q > pa_q) begin
        o_act_q <= act_q;
        o_page_q <= ADDR_W'(pa_q >> page_shift);
        o_pages_q <= END_W'(span >> page_shift);
      end else begin
        o_act_q <= PA_NONE;
        o_page_q <= '0;
        o_pages_q <= '0;
      end
    end
  end

  assign rsp_o.valid = out_vld_q;
  assign rsp_o.status = o_status_q;
  assign rsp_o.answer = o_answer_q;
  assign rsp_o.prot_action = o_act_q;
  assign rsp_o.prot_page = o_page_q;
  assign rsp_o.prot_pages = o_pages_q;
  assign rsp_o.ref_total = o_refs_q;
  assign rsp_o.object_total = o_objs_q;

endmodule
